FILE: rtl/core/promise_ballot_window_table_defines.svh
// Assertion macros used by the promise ballot window table checker.
// No dependencies; included by the checker file.
`ifndef PROMISE_BALLOT_WINDOW_TABLE_DEFINES_SVH
`define PROMISE_BALLOT_WINDOW_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PBWT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define PBWT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pbwt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the promise ballot window table.
// No dependencies; used by every module of the block.
package pbwt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ID_W        = 64;
   localparam int WIN_W       = 7;
   localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

   // request kind codes
   localparam logic KIND_SET    = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // response tuser bit positions
   localparam int RSP_FOUND_BIT = 0;
   localparam int RSP_END_BIT   = 1;
   localparam int RSP_UPD_BIT   = 2;

   // controller to datapath commands
   typedef struct packed {
      logic cap;
      logic cmp;
      logic sel;
      logic upd;
      logic evict;
   } pbwt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic rsp_busy;
      logic over_limit;
   } pbwt_stat_type;

endpackage

FILE: rtl/core/pbwt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the promise ballot window table.
// Depends on pbwt_pkg for the command and status structs.
module pbwt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   csr_tvalid,
   output logic                   csr_tready,
   input  pbwt_pkg::pbwt_stat_type stat,
   output pbwt_pkg::pbwt_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CMP   = 5'b00010,
      ST_SEL   = 5'b00100,
      ST_UPD   = 5'b01000,
      ST_EVICT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // window writes only between items; a waiting write goes before a request
   assign csr_tready = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !stat.rsp_busy && !csr_tvalid;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.cap  = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.sel  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_EVICT;
         end
         ST_EVICT: begin
            if (stat.over_limit) begin
               cmd.evict = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/pbwt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the promise ballot window table: sorted cell row, compares,
// floor select, insert/overwrite, eviction shift, response register.
// Depends on pbwt_pkg.
module pbwt_datapath #(
   parameter int DEPTH = pbwt_pkg::TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pbwt_pkg::pbwt_cmd_type        cmd,
   output pbwt_pkg::pbwt_stat_type       stat,
   input  logic                          win_we,
   input  logic [pbwt_pkg::WIN_W-1:0]    win_data,
   input  logic                          req_kind,
   input  logic [pbwt_pkg::ID_W-1:0]     req_inst,
   input  logic [pbwt_pkg::ID_W-1:0]     req_prop,
   input  logic [pbwt_pkg::ID_W-1:0]     req_node,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [pbwt_pkg::ID_W-1:0]     rsp_prop,
   output logic [pbwt_pkg::ID_W-1:0]     rsp_node,
   output logic                          rsp_has_end,
   output logic [pbwt_pkg::ID_W-1:0]     rsp_end,
   output logic                          rsp_updated
);

   localparam int ROWS = DEPTH + 1;            // spare row for the transient entry
   localparam int CW   = $clog2(DEPTH + 2);
   localparam int LW   = (CW > pbwt_pkg::WIN_W) ? CW : pbwt_pkg::WIN_W;
   localparam int W    = pbwt_pkg::ID_W;

   // captured request
   logic         kind_ff;
   logic [W-1:0] inst_ff, prop_ff, node_ff;

   // cell row
   logic [W-1:0] key_ff   [ROWS];
   logic [W-1:0] bprop_ff [ROWS];
   logic [W-1:0] bnode_ff [ROWS];
   logic [W-1:0] key_in   [ROWS];
   logic [W-1:0] bprop_in [ROWS];
   logic [W-1:0] bnode_in [ROWS];
   logic [CW-1:0] count_ff, count_in;
   logic [pbwt_pkg::WIN_W-1:0] window_ff;

   // compare and select stage registers
   logic [ROWS-1:0] vld, le_in, eq_in, le_ff, eq_ff;
   logic [ROWS-1:0] le_up, le_dn, last_oh, first_gt, end_oh;
   logic [ROWS-1:0] flr_oh_ff, ins_oh_ff, shift_ff;
   logic [W-1:0]    fp_in, fn_in, end_in;
   logic [W-1:0]    fp_ff, fn_ff, end_ff;
   logic            found_ff, has_end_ff, hit_ff, upd_ff;
   logic            better, do_store;

   // response register
   logic         rv_ff, rfound_ff, rend_ff, rupd_ff;
   logic [W-1:0] rprop_ff, rnode_ff, rendk_ff;

   logic [LW-1:0] win_ext, limit;

   // capture and configuration
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         kind_ff <= req_kind;
         inst_ff <= req_inst;
         prop_ff <= req_prop;
         node_ff <= req_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= pbwt_pkg::WIN_RESET;
      end else if (win_we) begin
         window_ff <= win_data;
      end
   end

   // parallel key compares, valid below the fill count
   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         vld[i]   = CW'(i) < count_ff;
         le_in[i] = vld[i] && (key_ff[i] <= inst_ff);
         eq_in[i] = vld[i] && (key_ff[i] == inst_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp) begin
         le_ff <= le_in;
         eq_ff <= eq_in;
      end
   end

   // floor and next-key select; keys are sorted so le is a prefix
   assign le_up    = {1'b0, le_ff[ROWS-1:1]};
   assign le_dn    = {le_ff[ROWS-2:0], 1'b1};
   assign last_oh  = le_ff & ~le_up;
   assign first_gt = ~le_ff & le_dn;
   assign end_oh   = first_gt & vld;

   always_comb begin
      fp_in  = '0;
      fn_in  = '0;
      end_in = '0;
      for (int i = 0; i < ROWS; i++) begin
         fp_in  = fp_in  | (bprop_ff[i] & {W{last_oh[i]}});
         fn_in  = fn_in  | (bnode_ff[i] & {W{last_oh[i]}});
         end_in = end_in | (key_ff[i]   & {W{end_oh[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sel) begin
         fp_ff      <= fp_in;
         fn_ff      <= fn_in;
         end_ff     <= end_in;
         found_ff   <= le_ff[0];
         has_end_ff <= |end_oh;
         hit_ff     <= |(last_oh & eq_ff);
         flr_oh_ff  <= last_oh;
         ins_oh_ff  <= first_gt;
         shift_ff   <= ~le_dn;
      end
   end

   // store decision: lexicographic ballot compare against the floor
   assign better   = (prop_ff > fp_ff) || ((prop_ff == fp_ff) && (node_ff > fn_ff));
   assign do_store = (kind_ff == pbwt_pkg::KIND_SET) && better;

   // per-cell next value: evict shifts down, insert shifts up above the slot
   for (genvar gi = 0; gi < ROWS; gi++) begin : g_cell
      logic [W-1:0] pk, pp, pn, nk, np, nn;
      if (gi == 0) begin : g_lo
         assign pk = key_ff[0];
         assign pp = bprop_ff[0];
         assign pn = bnode_ff[0];
      end else begin : g_mid
         assign pk = key_ff[gi-1];
         assign pp = bprop_ff[gi-1];
         assign pn = bnode_ff[gi-1];
      end
      if (gi == ROWS - 1) begin : g_hi
         assign nk = key_ff[gi];
         assign np = bprop_ff[gi];
         assign nn = bnode_ff[gi];
      end else begin : g_up
         assign nk = key_ff[gi+1];
         assign np = bprop_ff[gi+1];
         assign nn = bnode_ff[gi+1];
      end

      always_comb begin
         key_in[gi]   = key_ff[gi];
         bprop_in[gi] = bprop_ff[gi];
         bnode_in[gi] = bnode_ff[gi];
         if (cmd.evict) begin
            key_in[gi]   = nk;
            bprop_in[gi] = np;
            bnode_in[gi] = nn;
         end else if (cmd.upd && do_store) begin
            if (hit_ff) begin
               if (flr_oh_ff[gi]) begin
                  bprop_in[gi] = prop_ff;
                  bnode_in[gi] = node_ff;
               end
            end else if (ins_oh_ff[gi]) begin
               key_in[gi]   = inst_ff;
               bprop_in[gi] = prop_ff;
               bnode_in[gi] = node_ff;
            end else if (shift_ff[gi]) begin
               key_in[gi]   = pk;
               bprop_in[gi] = pp;
               bnode_in[gi] = pn;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROWS; i++) begin
         key_ff[i]   <= key_in[i];
         bprop_ff[i] <= bprop_in[i];
         bnode_ff[i] <= bnode_in[i];
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.evict) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.upd && do_store && !hit_ff) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         upd_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.upd) begin
            upd_ff <= do_store;
         end
      end
   end

   // window clamped to the table depth; evict only after a store
   assign win_ext = LW'(window_ff);
   assign limit   = (win_ext > LW'(DEPTH)) ? LW'(DEPTH) : win_ext;
   assign stat.over_limit = upd_ff && (LW'(count_ff) > limit);
   assign stat.rsp_busy   = rv_ff;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.upd) begin
         rv_ff <= 1'b1;
      end else if (rsp_ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         rfound_ff <= found_ff;
         rprop_ff  <= fp_ff;
         rnode_ff  <= fn_ff;
         rend_ff   <= has_end_ff;
         rendk_ff  <= end_ff;
         rupd_ff   <= do_store;
      end
   end

   assign rsp_valid   = rv_ff;
   assign rsp_found   = rfound_ff;
   assign rsp_prop    = rprop_ff;
   assign rsp_node    = rnode_ff;
   assign rsp_has_end = rend_ff;
   assign rsp_end     = rendk_ff;
   assign rsp_updated = rupd_ff;

endmodule

FILE: rtl/core/promise_ballot_window_table.sv
`timescale 1ns / 1ps
// Promise ballot window table: floor lookup and conditional ballot store
// over a sorted cell row. Depends on pbwt_pkg, pbwt_ctrl, pbwt_datapath.
//
// Usage:
//   req_* : one transaction per item; tuser is the kind (0 set, 1 lookup),
//           tdata carries instance, proposal and node ids.
//   rsp_* : one transaction per item with the floor ballot, the next key
//           above the instance and the stored flag.
//   csr_* : writes window_size; csr_tready is high only while no item is in
//           flight, and a waiting write holds off new requests.
// Response path: the request is captured, then the parallel key compare, floor
//   select, and store decision with response load are registered in turn.
// Evictions: one item at a time; a store is followed by E evictions,
//   one cell-row shift per cycle: 0 or 1 while the window is steady, up to
//   one more than the table depth after window_size is lowered.
//   A new request is taken only after the response register has been emptied.
// Reset: table empty, window_size 64, no response pending.
// Stall: the response register holds while rsp_tready is low; req_tready
//   stays low until it drains.
module promise_ballot_window_table #(
   parameter int DEPTH = pbwt_pkg::TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // instance_id, proposal_id, node_id
   input  logic [0:0]   req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // ballot_proposal, ballot_node, end_instance
   output logic [2:0]   rsp_tuser,   // found_ballot, has_end, updated
   input  logic         csr_tvalid,
   output logic         csr_tready,
   input  logic [7:0]   csr_tdata    // window_size
);

   localparam int W = pbwt_pkg::ID_W;

   pbwt_pkg::pbwt_cmd_type  cmd;
   pbwt_pkg::pbwt_stat_type stat;
   logic         found, has_end, updated;
   logic [W-1:0] bprop, bnode, endk;

   pbwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pbwt_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .win_we      (csr_tvalid && csr_tready),
      .win_data    (csr_tdata[pbwt_pkg::WIN_W-1:0]),
      .req_kind    (req_tuser[0]),
      .req_inst    (req_tdata[W-1:0]),
      .req_prop    (req_tdata[2*W-1:W]),
      .req_node    (req_tdata[3*W-1:2*W]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_found   (found),
      .rsp_prop    (bprop),
      .rsp_node    (bnode),
      .rsp_has_end (has_end),
      .rsp_end     (endk),
      .rsp_updated (updated)
   );

   assign rsp_tdata = {endk, bnode, bprop};
   always_comb begin
      rsp_tuser = '0;
      rsp_tuser[pbwt_pkg::RSP_FOUND_BIT] = found;
      rsp_tuser[pbwt_pkg::RSP_END_BIT]   = has_end;
      rsp_tuser[pbwt_pkg::RSP_UPD_BIT]   = updated;
   end

endmodule

FILE: rtl/core/pbwt_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the promise ballot window table and its bind.
// Depends on promise_ballot_window_table_defines.svh and pbwt_pkg.
`include "promise_ballot_window_table_defines.svh"

module pbwt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [0:0]   req_tuser,
   input logic [2:0]   rsp_tuser
);

   logic req_acc;
   logic lookup_acc;
   logic rsp_upd;
   assign req_acc    = req_tvalid && req_tready;
   assign lookup_acc = req_acc && (req_tuser[0] == pbwt_pkg::KIND_LOOKUP);
   assign rsp_upd    = rsp_tuser[pbwt_pkg::RSP_UPD_BIT];

   // a stalled response stays offered
   `PBWT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")

   // one item at a time: no new request right after one is taken
   `PBWT_ASSERT_NEXT(a_one_item, req_acc, !req_tready, "request taken while busy")

   // requests wait for the response register to drain
   `PBWT_ASSERT_NOW(a_ready_empty, req_tready, !rsp_tvalid, "ready with response pending")

   // a lookup's response comes up with no store
   `PBWT_ASSERT_NEXT(a_lookup_noupd, lookup_acc, ##3 (rsp_tvalid && !rsp_upd), "lookup stored")

endmodule

bind promise_ballot_window_table pbwt_checker u_pbwt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .req_tuser  (req_tuser),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench of the promise ballot window table: directed and random set and
// lookup items, window changes between phases, checked against a predictor.
// Depends on pbwt_pkg and promise_ballot_window_table.
module tb;

   typedef struct packed {
      logic        found;
      logic [63:0] prop;
      logic [63:0] node;
      logic        has_end;
      logic [63:0] end_key;
      logic        upd;
   } ballot_rsp_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // Predictor and queue of expected responses
   class ballot_scoreboard;
      logic [63:0] keys[$];
      logic [63:0] props[$];
      logic [63:0] nodes[$];
      int window = 64;
      ballot_rsp_type pending[$];

      function void note_request(logic kind, logic [63:0] inst,
                                 logic [63:0] prop, logic [63:0] node);
         ballot_rsp_type r;
         int p;
         int lim;
         p = 0;
         r = '0;
         while (p < keys.size() && keys[p] <= inst) p++;
         r.found = p > 0;
         if (r.found) begin
            r.prop = props[p-1];
            r.node = nodes[p-1];
         end
         r.has_end = p < keys.size();
         if (r.has_end) r.end_key = keys[p];
         if (kind == pbwt_pkg::KIND_SET &&
             (prop > r.prop || (prop == r.prop && node > r.node))) begin
            r.upd = 1'b1;
            if (r.found && keys[p-1] == inst) begin
               props[p-1] = prop;
               nodes[p-1] = node;
            end else begin
               keys.insert(p, inst);
               props.insert(p, prop);
               nodes.insert(p, node);
            end
            lim = window > pbwt_pkg::TABLE_DEPTH ? pbwt_pkg::TABLE_DEPTH : window;
            while (keys.size() > lim) begin
               void'(keys.pop_front());
               void'(props.pop_front());
               void'(nodes.pop_front());
            end
         end
         pending = {pending, r};
      endfunction

      task check_response(ballot_rsp_type got);
         ballot_rsp_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 64'd0, 64'd0);
            return;
         end
         w = pending.pop_front();
         if (got.found !== w.found)
            report_mismatch("found_ballot", 64'(got.found), 64'(w.found));
         if (got.prop !== w.prop) report_mismatch("ballot_proposal", got.prop, w.prop);
         if (got.node !== w.node) report_mismatch("ballot_node", got.node, w.node);
         if (got.has_end !== w.has_end)
            report_mismatch("has_end", 64'(got.has_end), 64'(w.has_end));
         if (got.end_key !== w.end_key) report_mismatch("end_instance", got.end_key, w.end_key);
         if (got.upd !== w.upd) report_mismatch("updated", 64'(got.upd), 64'(w.upd));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [191:0] req_tdata = '0;   // instance_id, proposal_id, node_id
   logic [0:0] req_tuser = '0;     // kind
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [191:0] rsp_tdata;        // ballot_proposal, ballot_node, end_instance
   logic [2:0] rsp_tuser;          // found_ballot, has_end, updated
   logic csr_tvalid = 0;
   logic csr_tready;
   logic [7:0] csr_tdata = '0;     // window_size

   ballot_scoreboard sb = new();
   int stall_mode = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   promise_ballot_window_table i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_tvalid, .csr_tready, .csr_tdata
   );

   // Receiver: stall pattern changes over the run; sample at the clock edge
   always @(posedge clock) begin
      ballot_rsp_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g.found = rsp_tuser[pbwt_pkg::RSP_FOUND_BIT];
         g.has_end = rsp_tuser[pbwt_pkg::RSP_END_BIT];
         g.upd = rsp_tuser[pbwt_pkg::RSP_UPD_BIT];
         g.prop = rsp_tdata[63:0];
         g.node = rsp_tdata[127:64];
         g.end_key = rsp_tdata[191:128];
         sb.check_response(g);
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   task automatic send_item(input logic kind, input logic [63:0] inst,
                            input logic [63:0] prop, input logic [63:0] node);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {node, prop, inst};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, inst, prop, node);
   endtask

   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      idle_cycles(1);
      while (sb.pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(input int w);
      csr_tvalid <= 1'b1;
      csr_tdata <= w[7:0];
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      sb.window = w & 8'h7f;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Small key space so lookups hit, overwrite and land between keys
   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 9))
         0: return rand64();
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2: return 64'd0;
         default: return 64'($urandom_range(0, 80));
      endcase
   endfunction

   function automatic logic [63:0] pick_val();
      case ($urandom_range(0, 7))
         0: return rand64();
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         default: return 64'($urandom_range(0, 12));
      endcase
   endfunction

   task automatic random_phase(input int n);
      int sent;
      int burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            send_item($urandom_range(0, 3) == 0 ? pbwt_pkg::KIND_LOOKUP : pbwt_pkg::KIND_SET,
                      pick_key(), pick_val(), pick_val());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 9));
      end
   endtask

   initial begin
      int windows[6];
      windows = '{3, 1, 127, 64, 65, 8};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty table, extremes, ties, overwrite, lookups
      send_item(pbwt_pkg::KIND_LOOKUP, 64'd5, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'd10, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'd10, 64'd0, 64'd1);
      send_item(pbwt_pkg::KIND_SET, 64'd10, 64'd0, 64'd1);
      send_item(pbwt_pkg::KIND_SET, 64'd20, 64'd1, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'd10, 64'd5, 64'd5);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'd15, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF);
      send_item(pbwt_pkg::KIND_SET, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'd30, 64'd1, 64'd0);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, rand64(), rand64());
      wait_drained();
      // Window lowered evicts nothing until the next store
      write_window(2);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'd0, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'd40, 64'd9, 64'd9);
      send_item(pbwt_pkg::KIND_SET, 64'd1, 64'd99, 64'd0);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'd50, 64'd0, 64'd0);
      wait_drained();
      write_window(0);
      send_item(pbwt_pkg::KIND_SET, 64'd7, 64'd3, 64'd3);
      send_item(pbwt_pkg::KIND_LOOKUP, 64'd7, 64'd0, 64'd0);
      send_item(pbwt_pkg::KIND_SET, 64'd8, 64'd1, 64'd1);
      wait_drained();
      // Random phases under several windows and receiver patterns
      foreach (windows[i]) begin
         write_window(windows[i]);
         stall_mode = i % 3;
         random_phase(115);
         wait_drained();
      end
      stall_mode = 0;
      repeat (20) @(posedge clock);
      if (error_count == 0 && sb.pending.size() == 0)
         $display("[promise_ballot_window_table] OK");
      else
         $display("[promise_ballot_window_table] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[promise_ballot_window_table] ERROR");
      $finish;
   end
endmodule
